// ===== sv/alt_pkg.sv =====
// Shared types and constants for the auto-layer tracker.
package alt_pkg;

    // Fixed field widths of the item and result beats.
    localparam int LAYER_W = 5;
    localparam int PAGE_W  = 8;
    localparam int ID_W    = 16;
    localparam int MODS_W  = 8;
    localparam int DROP_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IGN_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGN_NUMBER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGN_MOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONT_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONT_KEY_A = 3'd4;

    // Item kinds carried on the input tuser.
    localparam logic FUNC_TOGGLE = 1'b0;
    localparam logic FUNC_KEY    = 1'b1;

    // Result action codes carried on the output tuser.
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_DROP = 2'd2;
    localparam logic [1:0] ACT_FULL = 2'd3;

    // Keyboard usage page and the key ranges that may keep layers alive.
    localparam logic [PAGE_W-1:0] PAGE_KEYBOARD = 8'h07;
    localparam logic [ID_W-1:0] KEY_A     = 16'h0004;
    localparam logic [ID_W-1:0] KEY_Z     = 16'h001D;
    localparam logic [ID_W-1:0] KEY_1     = 16'h001E;
    localparam logic [ID_W-1:0] KEY_0     = 16'h0027;
    localparam logic [ID_W-1:0] KP_1      = 16'h0059;
    localparam logic [ID_W-1:0] KP_0      = 16'h0062;
    localparam logic [ID_W-1:0] KP_00     = 16'h00B0;
    localparam logic [ID_W-1:0] KP_000    = 16'h00B1;
    localparam logic [ID_W-1:0] MOD_FIRST = 16'h00E0;
    localparam logic [ID_W-1:0] MOD_LAST  = 16'h00E7;

    // One slot of the layer table.
    typedef struct packed {
        logic               active;
        logic [LAYER_W-1:0] layer;
    } t_slot;

    // Scalar configuration registers.
    typedef struct packed {
        logic       ign_alpha;
        logic       ign_number;
        logic       ign_mod;
        logic [2:0] cont_count;
    } t_cfg;

    // Key of a key event with its combined modifiers.
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [ID_W-1:0]   id;
        logic [MODS_W-1:0] mods;
    } t_key;

endpackage

// ===== sv/alt_slot_mem.sv =====
// Slot table memory with one registered read port, one write port and valid bits.
module alt_slot_mem #(
    parameter int MAX_SLOTS = 10,
    parameter int SLOT_W    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [SLOT_W-1:0]    i_rd_addr,
    output alt_pkg::t_slot       o_rd_data,
    input  logic                 i_we,
    input  logic [SLOT_W-1:0]    i_wr_addr,
    input  alt_pkg::t_slot       i_wr_data
);

    alt_pkg::t_slot        mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  r_valid;
    alt_pkg::t_slot        r_rd_data;
    logic                  r_rd_vld;

    // Valid bits: an entry never written reads as an empty slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, taken while the read enable is high.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_vld  <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/alt_keep.sv =====
// Decides whether a key press keeps the active layers alive.
module alt_keep #(
    parameter int CONTINUE_ENTRIES = 4
) (
    input  alt_pkg::t_cfg                    i_cfg,
    input  logic [CONTINUE_ENTRIES-1:0][31:0] i_cont_keys,
    input  alt_pkg::t_key                    i_key,
    output logic                             o_keep
);

    logic is_kb;
    logic is_alpha;
    logic is_number;
    logic is_mod;
    logic [CONTINUE_ENTRIES-1:0] cont_hit;

    // Ranges of the keyboard page.
    always_comb begin
        is_kb     = (i_key.page == alt_pkg::PAGE_KEYBOARD);
        is_alpha  = (i_key.id >= alt_pkg::KEY_A) && (i_key.id <= alt_pkg::KEY_Z);
        is_number = ((i_key.id >= alt_pkg::KEY_1) && (i_key.id <= alt_pkg::KEY_0)) ||
                    ((i_key.id >= alt_pkg::KP_1) && (i_key.id <= alt_pkg::KP_0)) ||
                    (i_key.id == alt_pkg::KP_00) || (i_key.id == alt_pkg::KP_000);
        is_mod    = (i_key.id >= alt_pkg::MOD_FIRST) && (i_key.id <= alt_pkg::MOD_LAST);
    end

    // Continue list: entries below the count match on page, id and all required mods.
    always_comb begin
        for (int i = 0; i < CONTINUE_ENTRIES; i++) begin
            cont_hit[i] = (3'(i) < i_cfg.cont_count) &&
                          (i_cont_keys[i][23:16] == i_key.page) &&
                          (i_cont_keys[i][15:0] == i_key.id) &&
                          ((i_cont_keys[i][31:24] & i_key.mods) == i_cont_keys[i][31:24]);
        end
    end

    assign o_keep = (i_cfg.ign_alpha && is_kb && is_alpha) ||
                    (i_cfg.ign_number && is_kb && is_number) ||
                    (i_cfg.ign_mod && is_kb && is_mod) ||
                    (|cont_hit);

endmodule

// ===== sv/auto_layer_tracker.sv =====
// Auto-layer tracker: slot table walk with read-modify-write of a slot memory.
// A toggle or key press walks every slot before its result is loaded; a key
// release or an out-of-range toggle goes straight to the result register once
// it is free. One item is in work at a time: the next is taken once the result
// of the last is loaded. Synchronous active-low reset empties the table and
// clears the configuration and control registers.
module auto_layer_tracker #(
    parameter int MAX_SLOTS        = 10,
    parameter int CONTINUE_ENTRIES = 4,
    parameter int NUM_LAYERS       = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: layer_id[5], key_page[8], key_code[16], key_down[1],
    // implicit_mods[8], explicit_mods[8], zero fill[2].
    input  logic [47:0] s_axis_tdata,
    // tuser: func[1].
    input  logic        s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: action_layer[5], dropped_layers[32], zero fill[3].
    output logic [39:0] m_axis_tdata,
    // tuser: action[2].
    output logic [1:0]  m_axis_tuser,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_PRESS  = 2'd2;

    // Configuration registers.
    alt_pkg::t_cfg                    r_cfg;
    logic [CONTINUE_ENTRIES-1:0][31:0] r_cont_keys;

    // Sequencer state.
    logic [1:0]          r_state, n_state;
    logic [1:0]          r_op;
    logic                r_rd_busy;
    logic [SLOT_W-1:0]   r_rd_idx;
    logic                r_cmp_valid;
    logic [SLOT_W-1:0]   r_cmp_idx;

    // Item payload and scan results.
    logic [alt_pkg::LAYER_W-1:0] r_layer;
    logic                        r_keep;
    logic                        r_hit_ok;
    logic [SLOT_W-1:0]           r_hit_idx;
    logic                        r_free_ok;
    logic [SLOT_W-1:0]           r_free_idx;
    logic [alt_pkg::DROP_W-1:0]  r_dropped;

    // Output register.
    logic                        r_out_valid;
    logic [1:0]                  r_out_action;
    logic [alt_pkg::LAYER_W-1:0] r_out_layer;
    logic [alt_pkg::DROP_W-1:0]  r_out_dropped;

    // Item fields.
    logic                        in_func;
    logic [alt_pkg::LAYER_W-1:0] in_layer;
    logic                        in_down;
    alt_pkg::t_key               in_key;
    logic                        accept;
    logic [1:0]                  n_op;
    logic                        keep;

    // Memory interface.
    alt_pkg::t_slot     rd_slot;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_wa;
    alt_pkg::t_slot     mem_wd;

    // Result of the finishing step.
    logic                        out_load;
    logic [1:0]                  fin_action;
    logic [alt_pkg::LAYER_W-1:0] fin_layer;

    // Unpack the item beat.
    always_comb begin
        in_func     = s_axis_tuser;
        in_layer    = s_axis_tdata[4:0];
        in_key.page = s_axis_tdata[12:5];
        in_key.id   = s_axis_tdata[28:13];
        in_down     = s_axis_tdata[29];
        in_key.mods = s_axis_tdata[37:30] | s_axis_tdata[45:38];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Classify the item: releases and out-of-range toggles need no table walk.
    always_comb begin
        if (in_func == alt_pkg::FUNC_TOGGLE) begin
            n_op = ({1'b0, in_layer} < 6'(NUM_LAYERS)) ? OP_TOGGLE : OP_NONE;
        end else begin
            n_op = in_down ? OP_PRESS : OP_NONE;
        end
    end

    alt_keep #(
        .CONTINUE_ENTRIES (CONTINUE_ENTRIES)
    ) u_keep (
        .i_cfg       (r_cfg),
        .i_cont_keys (r_cont_keys),
        .i_key       (in_key),
        .o_keep      (keep)
    );

    alt_slot_mem #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_rd_busy),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_slot),
        .i_we      (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_cont_keys <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                alt_pkg::REG_IGN_ALPHA:  r_cfg.ign_alpha  <= i_cfg_data[0];
                alt_pkg::REG_IGN_NUMBER: r_cfg.ign_number <= i_cfg_data[0];
                alt_pkg::REG_IGN_MOD:    r_cfg.ign_mod    <= i_cfg_data[0];
                alt_pkg::REG_CONT_COUNT: r_cfg.cont_count <= i_cfg_data[2:0];
                default: begin
                    for (int i = 0; i < CONTINUE_ENTRIES; i++) begin
                        if (i_cfg_idx == 3'(alt_pkg::REG_CONT_KEY_A + i)) begin
                            r_cont_keys[i] <= i_cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    // Finishing step: pick the toggle outcome or the key-press summary.
    always_comb begin
        out_load   = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);
        fin_action = alt_pkg::ACT_NONE;
        fin_layer  = '0;
        unique case (r_op)
            OP_TOGGLE: begin
                fin_layer = r_layer;
                if (r_hit_ok) begin
                    fin_action = alt_pkg::ACT_DROP;
                end else if (r_free_ok) begin
                    fin_action = alt_pkg::ACT_ON;
                end else begin
                    fin_action = alt_pkg::ACT_FULL;
                    fin_layer  = '0;
                end
            end
            OP_PRESS: begin
                fin_action = (r_dropped != '0) ? alt_pkg::ACT_DROP : alt_pkg::ACT_NONE;
            end
            default: begin
                fin_action = alt_pkg::ACT_NONE;
            end
        endcase
    end

    // Memory writes: clear a dropped slot during a key-press walk, or update the
    // chosen slot of a toggle as the result is loaded.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cmp_idx;
        mem_wd = '{active: 1'b0, layer: rd_slot.layer};
        if (r_op == OP_PRESS && r_cmp_valid && rd_slot.active && !r_keep) begin
            mem_we = 1'b1;
        end else if (r_op == OP_TOGGLE && out_load && (r_hit_ok || r_free_ok)) begin
            mem_we = 1'b1;
            mem_wa = r_hit_ok ? r_hit_idx : r_free_idx;
            mem_wd = '{active: !r_hit_ok, layer: r_layer};
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (n_op == OP_NONE) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cmp_valid && r_cmp_idx == LAST_SLOT) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_NONE;
            r_rd_busy   <= 1'b0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_cmp_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= r_rd_busy;
            r_cmp_idx   <= r_rd_idx;
            if (accept) begin
                r_op      <= n_op;
                r_rd_busy <= (n_op != OP_NONE);
                r_rd_idx  <= '0;
            end else if (r_rd_busy) begin
                if (r_rd_idx == LAST_SLOT) begin
                    r_rd_busy <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and walk results.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_layer   <= in_layer;
            r_keep    <= keep;
            r_hit_ok  <= 1'b0;
            r_free_ok <= 1'b0;
            r_dropped <= '0;
        end else if (r_cmp_valid) begin
            // First active slot holding the layer, and first empty slot.
            if (!r_hit_ok && rd_slot.active && rd_slot.layer == r_layer) begin
                r_hit_ok  <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
            if (!r_free_ok && !rd_slot.active) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            if (r_op == OP_PRESS && rd_slot.active && !r_keep) begin
                r_dropped <= r_dropped | (alt_pkg::DROP_W'(1) << rd_slot.layer);
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_action  <= fin_action;
            r_out_layer   <= fin_layer;
            r_out_dropped <= (r_op == OP_PRESS) ? r_dropped : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tdata  = {3'b000, r_out_dropped, r_out_layer};

`ifndef SYNTH
    // The table is never written while no item is in work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("slot memory written while idle");

    // An accepted item closes the input until its result is loaded.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    // Dropped layers appear only on a deactivation result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != alt_pkg::ACT_DROP) |-> (m_axis_tdata[36:5] == '0))
        else $error("dropped layers reported without a deactivation");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the auto-layer tracker: directed and random item streams.
module tb;

    localparam int SLOT_COUNT   = 10;
    localparam int CONT_ENTRIES = 4;
    localparam int ITEM_CYCLES  = SLOT_COUNT + 3;
    localparam int PHASE_ITEMS  = 70;
    localparam int PHASE_COUNT  = 6;

    // One item as it travels on the item stream.
    typedef struct packed {
        logic                        func;
        logic [alt_pkg::LAYER_W-1:0] layer;
        logic [alt_pkg::PAGE_W-1:0]  page;
        logic [alt_pkg::ID_W-1:0]    id;
        logic                        down;
        logic [alt_pkg::MODS_W-1:0]  imp_mods;
        logic [alt_pkg::MODS_W-1:0]  exp_mods;
    } t_event;

    // One result as it travels on the result stream.
    typedef struct packed {
        logic [1:0]                  action;
        logic [alt_pkg::LAYER_W-1:0] layer;
        logic [alt_pkg::DROP_W-1:0]  dropped;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    auto_layer_tracker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow copy of the layer table and the registers.
    logic                        slot_on  [SLOT_COUNT];
    logic [alt_pkg::LAYER_W-1:0] slot_lay [SLOT_COUNT];
    logic               ign_alpha;
    logic               ign_num;
    logic               ign_mod;
    logic [2:0]         cont_cnt;
    logic [31:0]        cont_key [CONT_ENTRIES];

    t_outcome outcomes_due[$];
    int err_count;
    int n_toggle;
    int n_press;
    int n_release;
    int n_checked;
    int in_gap_pct;
    int out_stall_pct;
    int stall_left = 0;

    // Key ids at the borders of the ignored key classes.
    logic [alt_pkg::ID_W-1:0] key_edges [10] = '{
        alt_pkg::KEY_A, alt_pkg::KEY_Z, alt_pkg::KEY_1, alt_pkg::KEY_0,
        alt_pkg::KP_1, alt_pkg::KP_0, alt_pkg::KP_00, alt_pkg::KP_000,
        alt_pkg::MOD_FIRST, alt_pkg::MOD_LAST};

    // Clock with a period of 10.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Decide whether a key press lets the active layers stay.
    function automatic logic key_continues(t_event ev);
        logic [alt_pkg::MODS_W-1:0] mods;
        logic              kb;
        logic              keep;
        logic [7:0]        need;
        int                n;
        int                i;
        mods = ev.imp_mods | ev.exp_mods;
        kb   = (ev.page == alt_pkg::PAGE_KEYBOARD);
        keep = 1'b0;
        if (ign_alpha && kb && ev.id >= alt_pkg::KEY_A && ev.id <= alt_pkg::KEY_Z)
            keep = 1'b1;
        if (ign_num && kb &&
                ((ev.id >= alt_pkg::KEY_1 && ev.id <= alt_pkg::KEY_0) ||
                 (ev.id >= alt_pkg::KP_1 && ev.id <= alt_pkg::KP_0) ||
                 ev.id == alt_pkg::KP_00 || ev.id == alt_pkg::KP_000))
            keep = 1'b1;
        if (ign_mod && kb && ev.id >= alt_pkg::MOD_FIRST && ev.id <= alt_pkg::MOD_LAST)
            keep = 1'b1;
        // A count above the list size saturates.
        n = (cont_cnt > CONT_ENTRIES) ? CONT_ENTRIES : int'(cont_cnt);
        for (i = 0; i < n; i++) begin
            need = cont_key[i][31:24];
            if (cont_key[i][23:16] == ev.page && cont_key[i][15:0] == ev.id &&
                    (need & mods) == need)
                keep = 1'b1;
        end
        return keep;
    endfunction

    // Work out the result of one item and advance the shadow table.
    function automatic t_outcome predict_outcome(t_event ev);
        t_outcome r;
        int       hit;
        int       free_s;
        int       i;
        logic     keep;
        r      = '0;
        hit    = -1;
        free_s = -1;
        if (ev.func == alt_pkg::FUNC_TOGGLE) begin
            for (i = 0; i < SLOT_COUNT; i++) begin
                if (hit < 0 && slot_on[i] && slot_lay[i] == ev.layer) hit = i;
                if (free_s < 0 && !slot_on[i]) free_s = i;
            end
            if (hit >= 0) begin
                slot_on[hit] = 1'b0;
                r.action     = alt_pkg::ACT_DROP;
                r.layer      = ev.layer;
            end else if (free_s >= 0) begin
                slot_on[free_s]  = 1'b1;
                slot_lay[free_s] = ev.layer;
                r.action         = alt_pkg::ACT_ON;
                r.layer          = ev.layer;
            end else begin
                r.action = alt_pkg::ACT_FULL;
            end
        end else if (ev.down) begin
            keep = key_continues(ev);
            for (i = 0; i < SLOT_COUNT; i++) begin
                if (slot_on[i] && !keep) begin
                    slot_on[i]               = 1'b0;
                    r.dropped[slot_lay[i]]   = 1'b1;
                end
            end
            if (r.dropped != '0) r.action = alt_pkg::ACT_DROP;
        end
        return r;
    endfunction

    // Idle length: zero unless a draw below pct hits; then mostly short, now and then long.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) < pct)
            return ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        return 0;
    endfunction

    // Send one item and record its expected result once the beat is taken.
    task automatic send_event(t_event ev);
        int gap;
        gap = pick_gap(in_gap_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, ev.exp_mods, ev.imp_mods, ev.down, ev.id, ev.page, ev.layer};
        s_axis_tuser  = ev.func;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        outcomes_due.push_back(predict_outcome(ev));
        if (ev.func == alt_pkg::FUNC_TOGGLE) n_toggle++;
        else if (ev.down) n_press++;
        else n_release++;
    endtask

    // Toggle item with random filler in the unused fields.
    task automatic toggle(logic [alt_pkg::LAYER_W-1:0] layer);
        t_event ev;
        ev       = t_event'({$urandom, $urandom});
        ev.func  = alt_pkg::FUNC_TOGGLE;
        ev.layer = layer;
        send_event(ev);
    endtask

    // Key event with a random layer field.
    task automatic key(logic [alt_pkg::PAGE_W-1:0] page, logic [alt_pkg::ID_W-1:0] id,
                       logic down, logic [alt_pkg::MODS_W-1:0] imp_mods,
                       logic [alt_pkg::MODS_W-1:0] exp_mods);
        t_event ev;
        ev.func     = alt_pkg::FUNC_KEY;
        ev.layer    = alt_pkg::LAYER_W'($urandom);
        ev.page     = page;
        ev.id       = id;
        ev.down     = down;
        ev.imp_mods = imp_mods;
        ev.exp_mods = exp_mods;
        send_event(ev);
    endtask

    // Drop the item valid and wait until every result is back.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (outcomes_due.size() > 0) @(posedge i_clk);
        repeat (ITEM_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the shadow copy follows at the write edge.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            alt_pkg::REG_IGN_ALPHA:  ign_alpha = data[0];
            alt_pkg::REG_IGN_NUMBER: ign_num   = data[0];
            alt_pkg::REG_IGN_MOD:    ign_mod   = data[0];
            alt_pkg::REG_CONT_COUNT: cont_cnt  = data[2:0];
            default:                 cont_key[idx - alt_pkg::REG_CONT_KEY_A] = data;
        endcase
    endtask

    // Write the whole register set, then release the write enable.
    task automatic apply_settings(logic a, logic n, logic m, logic [2:0] cnt,
                                  logic [31:0] keys [CONT_ENTRIES]);
        int i;
        wait_idle();
        write_reg(alt_pkg::REG_IGN_ALPHA, {31'd0, a});
        write_reg(alt_pkg::REG_IGN_NUMBER, {31'd0, n});
        write_reg(alt_pkg::REG_IGN_MOD, {31'd0, m});
        write_reg(alt_pkg::REG_CONT_COUNT, {29'd0, cnt});
        for (i = 0; i < CONT_ENTRIES; i++)
            write_reg(alt_pkg::REG_CONT_KEY_A + 3'(i), keys[i]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Fill the table, hit the full case, free and reclaim a slot, then drop all.
    task automatic test_table_fill();
        int i;
        toggle(5'd0);
        toggle(5'd31);
        for (i = 1; i <= SLOT_COUNT - 2; i++) toggle(5'(i));
        toggle(5'd20);
        toggle(5'd31);
        toggle(5'd20);
        key(8'hFF, 16'hFFFF, 1'b0, 8'hFF, 8'hFF);
        key(alt_pkg::PAGE_KEYBOARD, alt_pkg::KEY_A, 1'b1, 8'h00, 8'h00);
    endtask

    // With every ignore class on, border keys other than keypad 1 and 0 keep the layer; one outside drops it.
    task automatic test_ignore_classes();
        logic [31:0] keys [CONT_ENTRIES];
        int i;
        keys = '{default: 32'd0};
        apply_settings(1'b1, 1'b1, 1'b1, 3'd0, keys);
        toggle(5'd3);
        for (i = 0; i < 10; i++)
            if (i != 4 && i != 5)
                key(alt_pkg::PAGE_KEYBOARD, key_edges[i], 1'b1, 8'h00, 8'h00);
        key(alt_pkg::PAGE_KEYBOARD, alt_pkg::MOD_LAST + 16'd1, 1'b1, 8'h00, 8'h00);
    endtask

    // Continue list with an all-ones last entry and a saturated count: modifiers must all be there.
    task automatic test_continue_list();
        logic [31:0] keys [CONT_ENTRIES];
        keys = '{32'h0107_0004, 32'h0000_0000, 32'h8000_1234, 32'hFFFF_FFFF};
        apply_settings(1'b0, 1'b0, 1'b0, 3'd7, keys);
        toggle(5'd9);
        key(8'hFF, 16'hFFFF, 1'b1, 8'hF0, 8'h0F);
        key(8'hFF, 16'hFFFF, 1'b1, 8'hF0, 8'h0E);
    endtask

    // Random item: toggles at the given percentage, else keys that mostly matter to the current settings.
    function automatic t_event random_event(int toggle_pct);
        t_event      ev;
        logic [31:0] k;
        int          pick;
        ev       = t_event'({$urandom, $urandom});
        ev.layer = ($urandom_range(9) < 7) ? 5'($urandom_range(0, 11)) : 5'($urandom);
        pick     = $urandom_range(99);
        if (pick < toggle_pct) begin
            ev.func = alt_pkg::FUNC_TOGGLE;
        end else begin
            ev.func = alt_pkg::FUNC_KEY;
            ev.down = ($urandom_range(9) != 0);
            case ($urandom_range(3))
                0: begin
                    ev.page = alt_pkg::PAGE_KEYBOARD;
                    ev.id   = key_edges[$urandom_range(9)] + 16'($urandom_range(2)) - 16'd1;
                end
                1: begin
                    k       = cont_key[$urandom_range(CONT_ENTRIES - 1)];
                    ev.page = k[23:16];
                    ev.id   = k[15:0];
                    if ($urandom_range(1)) begin
                        ev.imp_mods = ev.imp_mods | k[31:24];
                    end else begin
                        ev.imp_mods = ev.imp_mods & 8'($urandom);
                        ev.exp_mods = ev.exp_mods & 8'($urandom);
                    end
                end
                2: begin
                    ev.page = alt_pkg::PAGE_KEYBOARD;
                    ev.id   = 16'($urandom_range(0, 255));
                end
                default: ;
            endcase
        end
        return ev;
    endfunction

    // Random phases, each under its own settings and idling mix.
    task automatic test_random();
        logic [31:0] keys [CONT_ENTRIES];
        int p;
        int i;
        int toggle_pct;
        for (p = 0; p < PHASE_COUNT; p++) begin
            for (i = 0; i < CONT_ENTRIES; i++) begin
                keys[i][31:24] = 8'($urandom & $urandom & $urandom);
                keys[i][23:16] = $urandom_range(1) ? alt_pkg::PAGE_KEYBOARD : 8'($urandom);
                keys[i][15:0]  = $urandom_range(1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
            end
            if (p == 0) begin
                keys = '{default: 32'd0};
                apply_settings(1'b0, 1'b0, 1'b0, 3'd0, keys);
            end else if (p == PHASE_COUNT - 1) begin
                apply_settings(1'b1, 1'b1, 1'b1, 3'd4, keys);
            end else begin
                apply_settings(1'($urandom), 1'($urandom), 1'($urandom),
                               3'($urandom_range(0, 7)), keys);
            end
            // The first phase runs without any idling on either side.
            in_gap_pct    = (p == 0) ? 0 : 10 * $urandom_range(1, 6);
            out_stall_pct = (p == 0) ? 0 : 10 * $urandom_range(1, 6);
            toggle_pct    = (p % 2) ? 70 : 45;
            for (i = 0; i < PHASE_ITEMS; i++) send_event(random_event(toggle_pct));
        end
    endtask

    // Result side: random stalls on tready.
    always @(negedge i_clk) begin
        if (stall_left == 0) stall_left = pick_gap(out_stall_pct);
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcomes_due.size() == 0) begin
                $error("result beat with no item outstanding");
                err_count++;
            end else begin
                want = outcomes_due.pop_front();
                n_checked++;
                if (m_axis_tuser !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[4:0] !== want.layer) begin
                    $error("action_layer: expected %0d, got %0d", want.layer, m_axis_tdata[4:0]);
                    err_count++;
                end
                if (m_axis_tdata[36:5] !== want.dropped) begin
                    $error("dropped_layers: expected %h, got %h", want.dropped,
                           m_axis_tdata[36:5]);
                    err_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        int i;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = alt_pkg::FUNC_TOGGLE;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = alt_pkg::REG_IGN_ALPHA;
        i_cfg_data    = '0;
        err_count     = 0;
        n_toggle      = 0;
        n_press       = 0;
        n_release     = 0;
        n_checked     = 0;
        in_gap_pct    = 30;
        out_stall_pct = 30;
        ign_alpha     = 1'b0;
        ign_num       = 1'b0;
        ign_mod       = 1'b0;
        cont_cnt      = '0;
        for (i = 0; i < CONT_ENTRIES; i++) cont_key[i] = '0;
        for (i = 0; i < SLOT_COUNT; i++) begin
            slot_on[i]  = 1'b0;
            slot_lay[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_fill();
        test_ignore_classes();
        test_continue_list();
        test_random();
        wait_idle();

        $display("Run covered %0d toggles, %0d key presses and %0d key releases;",
                 n_toggle, n_press, n_release);
        $display("%0d result beats were compared, %0d mismatches.", n_checked, err_count);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
